### sv/hslca_pkg.sv
// ----------------------------------------------------------------------------
// hslca_pkg
// Shared types, codes and hue constants for the HSL color adjuster.
// ----------------------------------------------------------------------------
package hslca_pkg;

	// hue in 1/64 degree, 0..23039
	typedef logic [14:0] hue_t;
	// saturation, 0..65536 where 65536 is one
	typedef logic [16:0] sat_t;

	localparam int SAT_BITS  = 17;
	localparam int HUE_FULL  = 23040;
	localparam int HUE_THIRD = 7680;
	localparam int HUE_SIXTH = 3840;
	localparam int SAT_ONE   = 65536;
	localparam int RATIO_ONE = 16384;

	// half of the ramp divisor 3840 * 2 * 65536
	localparam logic [31:0] HALF_RAMP_DEN = 32'd251658240;
	// floor(2^20 / 15), used for the divide by 15 of the ramp
	localparam logic [16:0] RECIP_15 = 17'd69905;

	typedef enum logic [1:0] {
		MODE_SHADE = 2'd0,
		MODE_DRIFT = 2'd1,
		MODE_SHIFT = 2'd2,
		MODE_SET   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		REG_MODE   = 4'd0,
		REG_RATIO  = 4'd1,
		REG_OFFSET = 4'd2,
		REG_TARGET = 4'd3
	} reg_idx_t;

	// which component is the maximum
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// wrap a hue sum in -32768..55806 into 0..23039
	function automatic hue_t wrap_hue(logic signed [17:0] s);
		logic signed [17:0] w;
		if (s < -18'sd23040) begin
			w = s + 18'sd46080;
		end else if (s < 18'sd0) begin
			w = s + 18'sd23040;
		end else if (s < 18'sd23040) begin
			w = s;
		end else if (s < 18'sd46080) begin
			w = s - 18'sd23040;
		end else begin
			w = s - 18'sd46080;
		end
		return hue_t'(w);
	endfunction

endpackage

### sv/hsl_color_adjust.sv
// ----------------------------------------------------------------------------
// hsl_color_adjust
// RGB to HSL, lightness/hue adjust per mode, HSL back to RGB, fully pipelined.
// Throughput: one pixel per clock, busy never rises.
// Pipeline: three front stages, 17 divider stages and nine back stages lie
// between the accepting edge and the registered result on the output ports.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module hsl_color_adjust import hslca_pkg::*; #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out
);

	localparam int CB    = COMPONENT_BITS;
	localparam int LW    = CB + 1;
	localparam int SN_W  = CB + 17;
	localparam int HN_W  = CB + 14;
	localparam int MW    = CB + 19;
	localparam int NUMW  = MW + 13;
	localparam int TW    = CB + 5;
	localparam int QOW   = TW - 3;
	localparam int XW    = LW + 17;
	localparam int RW    = (LW + 2 > 17) ? LW + 2 : 17;
	localparam int QW    = SAT_BITS;
	localparam int DEPTH = QW + 12;

	localparam logic [CB-1:0] MAXV  = '1;
	localparam logic [LW-1:0] TWO_M = {MAXV, 1'b0};

	typedef struct packed {
		logic [LW-1:0] ls;
		logic          gray;
		logic          neg;
		sector_t       sec;
	} side_t;

	// ---------------- configuration ----------------
	mode_t              mode_q;
	logic [15:0]        ratio_q;
	logic signed [15:0] offset_q;
	logic [15:0]        target_q;
	logic signed [15:0] hue_add_q;
	logic [XW-1:0]      setx_q;
	logic [LW-1:0]      ls_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SHADE;
			ratio_q  <= 16'(RATIO_ONE);
			offset_q <= '0;
			target_q <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_RATIO:  ratio_q  <= cfg_data;
				REG_OFFSET: offset_q <= $signed(cfg_data);
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// values derived from the registers; they settle long before an item needs them
	logic [19:0]        up_sum;
	logic [16:0]        dn_sum;
	logic signed [15:0] drift;
	logic signed [15:0] hue_add_d;
	logic [XW-16-1:0]   fq0;
	logic [RW-1:0]      fr;
	logic [16:0]        flo;
	logic               fc;
	logic [XW-16-1:0]   fq;

	always_comb begin
		up_sum = 20'(ratio_q) * 20'd11 + 20'd512;
		dn_sum = 17'd3 * (17'(RATIO_ONE) - 17'(ratio_q)) + 17'd32;
		if (ratio_q >= 16'(RATIO_ONE)) begin
			drift = -$signed(16'(up_sum[19:10]));
		end else begin
			drift = $signed(16'(dn_sum[16:6]));
		end
		case (mode_q)
			MODE_DRIFT: hue_add_d = drift;
			MODE_SHIFT: hue_add_d = offset_q;
			default:    hue_add_d = '0;
		endcase
		// divide by 65535 by folding the high half back onto the low half
		fq0 = setx_q[XW-1:16];
		fr  = RW'(setx_q[15:0]) + RW'(fq0);
		flo = 17'(fr[15:0]) + 17'(fr[RW-1:16]);
		fc  = flo >= 17'd65535;
		fq  = fq0 + (XW-16)'(fr[RW-1:16]) + (XW-16)'(fc);
	end

	always_ff @(posedge clk) begin
		hue_add_q <= hue_add_d;
		setx_q    <= XW'(target_q) * XW'(TWO_M) + XW'(32767);
		ls_set_q  <= LW'(fq);
	end

	// ---------------- s1: capture ----------------
	logic          v_s1;
	logic [CB-1:0] r_s1, g_s1, b_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= red_in[CB-1:0];
		g_s1 <= green_in[CB-1:0];
		b_s1 <= blue_in[CB-1:0];
	end

	// ---------------- s2: max, min, lightness ----------------
	logic [CB-1:0]   hi_c, lo_c, delta_c, den_c, na_c, nb_c, n_c;
	logic [LW-1:0]   ls_c, rest_c;
	logic [CB+13:0]  dprod_c;
	sector_t         sec_c;
	logic            v_s2, gray_s2, neg_s2;
	logic [CB-1:0]   delta_s2, den_s2, n_s2;
	logic [LW-1:0]   ls_s2;
	sector_t         sec_s2;

	always_comb begin
		hi_c    = (r_s1 > g_s1) ? ((r_s1 > b_s1) ? r_s1 : b_s1) : ((g_s1 > b_s1) ? g_s1 : b_s1);
		lo_c    = (r_s1 > g_s1) ? ((g_s1 < b_s1) ? g_s1 : b_s1) : ((r_s1 < b_s1) ? r_s1 : b_s1);
		delta_c = hi_c - lo_c;
		ls_c    = LW'(hi_c) + LW'(lo_c);
		rest_c  = TWO_M - ls_c;
		den_c   = (ls_c <= LW'(MAXV)) ? ls_c[CB-1:0] : rest_c[CB-1:0];
		dprod_c = (CB+14)'(delta_c) * (CB+14)'(10000);
		if (r_s1 == hi_c) begin
			na_c  = g_s1;
			nb_c  = b_s1;
			sec_c = SEC_RED;
		end else if (g_s1 == hi_c) begin
			na_c  = b_s1;
			nb_c  = r_s1;
			sec_c = SEC_GREEN;
		end else begin
			na_c  = r_s1;
			nb_c  = g_s1;
			sec_c = SEC_BLUE;
		end
		n_c = (na_c < nb_c) ? nb_c - na_c : na_c - nb_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		delta_s2 <= delta_c;
		den_s2   <= den_c;
		ls_s2    <= ls_c;
		gray_s2  <= dprod_c < (CB+14)'(MAXV);
		neg_s2   <= na_c < nb_c;
		n_s2     <= n_c;
		sec_s2   <= sec_c;
	end

	// ---------------- s3: divider operands ----------------
	logic            v_s3;
	logic [SN_W-1:0] num_sat_s3;
	logic [CB-1:0]   den_sat_s3;
	logic [HN_W-1:0] num_hue_s3;
	logic [CB:0]     den_hue_s3;
	side_t           side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_sat_s3   <= (SN_W'(delta_s2) << 16) + SN_W'(den_s2 >> 1);
		den_sat_s3   <= den_s2;
		num_hue_s3   <= HN_W'(n_s2) * HN_W'(HUE_THIRD) + HN_W'(delta_s2);
		den_hue_s3   <= {delta_s2, 1'b0};
		side_s3.ls   <= ls_s2;
		side_s3.gray <= gray_s2;
		side_s3.neg  <= neg_s2;
		side_s3.sec  <= sec_s2;
	end

	// ---------------- dividers, side data rides alongside ----------------
	logic [QW-1:0] sat_quo, hue_quo;
	logic          v_dq    [QW];
	side_t         side_dq [QW];

	hslca_div #(.NW(SN_W), .DW(CB), .QW(QW)) u_sat_div (
		.clk (clk),
		.num (num_sat_s3),
		.den (den_sat_s3),
		.quo (sat_quo)
	);

	hslca_div #(.NW(HN_W), .DW(CB + 1), .QW(QW)) u_hue_div (
		.clk (clk),
		.num (num_hue_s3),
		.den (den_hue_s3),
		.quo (hue_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				v_dq[i] <= 1'b0;
			end
		end else begin
			v_dq[0] <= v_s3;
			for (int i = 1; i < QW; i++) begin
				v_dq[i] <= v_dq[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_dq[0] <= side_s3;
		for (int i = 1; i < QW; i++) begin
			side_dq[i] <= side_dq[i-1];
		end
	end

	// ---------------- s4: hue and saturation, shade product ----------------
	side_t              sd;
	logic signed [17:0] base_c, mag_c, hsum_c;
	logic               v_s4;
	hue_t               hue_s4;
	sat_t               sat_s4;
	logic [LW-1:0]      ls_s4;
	logic [LW+15:0]     prod_s4;

	always_comb begin
		sd = side_dq[QW-1];
		case (sd.sec)
			SEC_GREEN: base_c = 18'(HUE_THIRD);
			SEC_BLUE:  base_c = 18'(2 * HUE_THIRD);
			default:   base_c = '0;
		endcase
		mag_c  = $signed({6'b0, hue_quo[11:0]});
		hsum_c = sd.neg ? base_c - mag_c : base_c + mag_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_dq[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		hue_s4  <= sd.gray ? '0 : wrap_hue(hsum_c);
		if (sd.gray) begin
			sat_s4 <= '0;
		end else begin
			sat_s4 <= (sat_quo > QW'(SAT_ONE)) ? sat_t'(SAT_ONE) : sat_t'(sat_quo);
		end
		ls_s4   <= sd.ls;
		prod_s4 <= (LW+16)'(sd.ls) * (LW+16)'(ratio_q);
	end

	// ---------------- s5: adjust ----------------
	logic [LW+16:0]     sh_sum_c;
	logic [LW+2:0]      shade_c;
	logic [LW-1:0]      ls_adj_c;
	logic signed [17:0] hs_c;
	logic               v_s5;
	logic [LW-1:0]      ls_s5;
	hue_t               hue_s5;
	sat_t               sat_s5;

	always_comb begin
		sh_sum_c = (LW+17)'(prod_s4) + (LW+17)'(8192);
		shade_c  = sh_sum_c[LW+16:14];
		case (mode_q)
			MODE_SHADE, MODE_DRIFT: begin
				ls_adj_c = (shade_c > (LW+3)'(TWO_M)) ? TWO_M : shade_c[LW-1:0];
			end
			MODE_SET: ls_adj_c = ls_set_q;
			default:  ls_adj_c = ls_s4;
		endcase
		hs_c = $signed({3'b000, hue_s4}) + 18'(hue_add_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ls_s5  <= ls_adj_c;
		hue_s5 <= wrap_hue(hs_c);
		sat_s5 <= sat_s4;
	end

	// ---------------- s6: m1/m2 partial products ----------------
	logic          v_s6, big_s6;
	logic [MW-1:0] pa_s6, pb_s6, pc_s6;
	hue_t          hue_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pa_s6  <= MW'(ls_s5) * MW'(18'(SAT_ONE) + 18'(sat_s5));
		pb_s6  <= MW'(ls_s5) * MW'(18'(SAT_ONE) - 18'(sat_s5));
		pc_s6  <= MW'(sat_s5) * MW'(TWO_M);
		big_s6 <= ls_s5 > LW'(MAXV);
		hue_s6 <= hue_s5;
	end

	// ---------------- s7: m1, m2 and lane hues ----------------
	logic          v_s7;
	logic [MW-1:0] m1_s7, m2_s7;
	hue_t          hc_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		m2_s7    <= big_s6 ? pb_s6 + pc_s6 : pa_s6;
		m1_s7    <= big_s6 ? pa_s6 - pc_s6 : pb_s6;
		hc_s7[0] <= wrap_hue($signed({3'b000, hue_s6}) + 18'(HUE_THIRD));
		hc_s7[1] <= hue_s6;
		hc_s7[2] <= wrap_hue($signed({3'b000, hue_s6}) - 18'(HUE_THIRD));
	end

	// ---------------- s8: ramp selection per lane ----------------
	logic          v_s8;
	logic [MW-1:0] m1_s8, m2_s8, diff_s8;
	logic          sel_s8 [3];
	logic [11:0]   f_s8   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		m1_s8   <= m1_s7;
		m2_s8   <= m2_s7;
		diff_s8 <= m2_s7 - m1_s7;
		for (int l = 0; l < 3; l++) begin
			if (hc_s7[l] < hue_t'(HUE_SIXTH)) begin
				sel_s8[l] <= 1'b0;
				f_s8[l]   <= hc_s7[l][11:0];
			end else if (hc_s7[l] < hue_t'(3 * HUE_SIXTH)) begin
				sel_s8[l] <= 1'b1;
				f_s8[l]   <= '0;
			end else if (hc_s7[l] < hue_t'(4 * HUE_SIXTH)) begin
				sel_s8[l] <= 1'b0;
				f_s8[l]   <= 12'(hue_t'(4 * HUE_SIXTH) - hc_s7[l]);
			end else begin
				sel_s8[l] <= 1'b0;
				f_s8[l]   <= '0;
			end
		end
	end

	// ---------------- s9: ramp products ----------------
	logic            v_s9;
	logic [NUMW-1:0] p0_s9 [3];
	logic [NUMW-1:0] p1_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			p0_s9[l] <= NUMW'(sel_s8[l] ? m2_s8 : m1_s8) * NUMW'(HUE_SIXTH);
			p1_s9[l] <= NUMW'(diff_s8) * NUMW'(f_s8[l]);
		end
	end

	// ---------------- s10: round, drop the power of two ----------------
	logic            v_s10;
	logic [NUMW-1:0] num_c [3];
	logic [TW-1:0]   t_s10 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num_c[l] = p0_s9[l] + p1_s9[l] + NUMW'(HALF_RAMP_DEN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			t_s10[l] <= num_c[l][25 +: TW];
		end
	end

	// ---------------- s11: divide by 15, estimate ----------------
	logic           v_s11;
	logic [TW+16:0] qp_c [3];
	logic [TW-1:0]  t_s11 [3];
	logic [QOW-1:0] q0_s11 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qp_c[l] = (TW+17)'(t_s10[l]) * (TW+17)'(RECIP_15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			t_s11[l]  <= t_s10[l];
			q0_s11[l] <= qp_c[l][20 +: QOW];
		end
	end

	// ---------------- s12: correct, clamp, present ----------------
	logic           v_s12;
	logic [TW-1:0]  rr_c [3];
	logic [QOW-1:0] q_c  [3];
	logic [CB-1:0]  out_s12 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rr_c[l] = t_s11[l] - TW'(q0_s11[l]) * TW'(15);
			q_c[l]  = q0_s11[l] + QOW'(rr_c[l] >= TW'(15));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			out_s12[l] <= (q_c[l] > QOW'(MAXV)) ? MAXV : q_c[l][CB-1:0];
		end
	end

	assign done      = v_s12;
	assign red_out   = 16'(out_s12[0]);
	assign green_out = 16'(out_s12[1]);
	assign blue_out  = 16'(out_s12[2]);

	// ---------------- assertions ----------------
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##DEPTH done)
		else $error("accepted pixel did not come out on time");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DEPTH))
		else $error("result strobe without an accepted pixel");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> sat_s5 <= sat_t'(SAT_ONE))
		else $error("saturation above one");

	a_ramp_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (m1_s8 <= m2_s8) && (ls_s5 <= TWO_M || !v_s5))
		else $error("m1 above m2 or lightness above range");

endmodule

### sv/hslca_div.sv
// ----------------------------------------------------------------------------
// hslca_div
// Pipelined restoring divider: one quotient bit per register stage.
// The dividend must be below den * 2^QW.
// ----------------------------------------------------------------------------
module hslca_div #(
	parameter int NW = 33,
	parameter int DW = 16,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW = NW + DW + QW;

	logic [NW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [CW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign trial = CW'(den_in) << (QW - 1 - k);
		assign take  = CW'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			rem_q[k] <= take ? rem_in - trial[NW-1:0] : rem_in;
			den_q[k] <= den_in;
			quo_q[k] <= {quo_in[QW-2:0], take};
		end
	end

	assign quo = quo_q[QW-1];

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsl_color_adjust. A directed table covers the color
// extremes, near-gray pixels and every mode, then random
// pixels run under a series of register settings. Every result is compared
// with a behavioral HSL adjust model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
	import hslca_pkg::*;

	localparam int          LATENCY    = 29;
	localparam int          CYCLE_CAP  = 300000;
	localparam int          RAND_PHASES = 13;
	localparam int          PHASE_LEN  = 100;
	localparam logic [3:0]  REG_UNUSED = 4'd15;
	localparam longint      MAXV       = 65535;
	localparam longint      TWO_M      = 2 * 65535;

	typedef struct {
		logic        cfg;
		mode_t       md;
		logic [15:0] ratio;
		logic [15:0] offset;
		logic [15:0] target;
		logic [15:0] r, g, b;
		logic        chk;
		logic [15:0] er, eg, eb;
	} row_t;

	typedef struct {
		logic [15:0] r, g, b;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] red_in = '0, green_in = '0, blue_in = '0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        done;
	logic [15:0] red_out, green_out, blue_out;

	// adjuster registers as the model sees them
	mode_t       cur_mode;
	logic [15:0] cur_ratio;
	logic [15:0] cur_offset;
	logic [15:0] cur_target;

	pixel_t      pending_pixels[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          pixels_sent = 0;
	int          settings_used = 0;
	longint      cycles = 0;

	hsl_color_adjust uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint wrap_deg(longint h);
		longint w;
		w = h % HUE_FULL;
		if (w < 0) w = w + HUE_FULL;
		return w;
	endfunction

	function automatic longint ramp(longint hc, longint m1s, longint m2s);
		longint den, num, v;
		den = longint'(HUE_SIXTH) * 2 * SAT_ONE;
		if (hc < HUE_SIXTH)
			num = m1s * HUE_SIXTH + (m2s - m1s) * hc;
		else if (hc < 3 * HUE_SIXTH)
			num = m2s * HUE_SIXTH;
		else if (hc < 4 * HUE_SIXTH)
			num = m1s * HUE_SIXTH + (m2s - m1s) * (4 * HUE_SIXTH - hc);
		else
			num = m1s * HUE_SIXTH;
		v = (num + den / 2) / den;
		return (v > MAXV) ? MAXV : v;
	endfunction

	function automatic pixel_t adjust_pixel(pixel_t px);
		longint r, g, b, hi, lo, delta, ls, sat, hue, den, numh, base, mag, drift;
		longint m1s, m2s;
		pixel_t res;
		r = px.r; g = px.g; b = px.b;
		hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		lo = (r > g) ? ((g < b) ? g : b) : ((r < b) ? r : b);
		delta = hi - lo;
		ls = hi + lo;
		sat = 0;
		hue = 0;
		if (delta * 10000 >= MAXV) begin
			den = (ls <= MAXV) ? ls : TWO_M - ls;
			sat = (delta * SAT_ONE + den / 2) / den;
			if (sat > SAT_ONE) sat = SAT_ONE;
			if (r == hi) begin
				numh = g - b; base = 0;
			end else if (g == hi) begin
				numh = b - r; base = HUE_THIRD;
			end else begin
				numh = r - g; base = 2 * HUE_THIRD;
			end
			mag = (2 * HUE_SIXTH * ((numh < 0) ? -numh : numh) + delta) / (2 * delta);
			hue = wrap_deg(base + ((numh < 0) ? -mag : mag));
		end
		case (cur_mode)
			MODE_SHADE, MODE_DRIFT: begin
				ls = (ls * cur_ratio + 8192) >> 14;
				if (ls > TWO_M) ls = TWO_M;
				if (cur_mode == MODE_DRIFT) begin
					if (cur_ratio >= RATIO_ONE)
						drift = -((11 * longint'(cur_ratio) + 512) / 1024);
					else
						drift = (3 * (RATIO_ONE - longint'(cur_ratio)) + 32) / 64;
					hue = wrap_deg(hue + drift);
				end
			end
			MODE_SHIFT: hue = wrap_deg(hue + longint'($signed(cur_offset)));
			default: ls = (longint'(cur_target) * TWO_M + 32767) / 65535;
		endcase
		if (ls <= MAXV) begin
			m2s = ls * (SAT_ONE + sat);
			m1s = ls * (SAT_ONE - sat);
		end else begin
			m2s = ls * (SAT_ONE - sat) + sat * TWO_M;
			m1s = ls * (SAT_ONE + sat) - sat * TWO_M;
		end
		res.r = 16'(ramp(wrap_deg(hue + HUE_THIRD), m1s, m2s));
		res.g = 16'(ramp(hue, m1s, m2s));
		res.b = 16'(ramp(wrap_deg(hue - HUE_THIRD), m1s, m2s));
		return res;
	endfunction

	// compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (pending_pixels.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h", red_out, green_out, blue_out);
			end else begin
				want = pending_pixels.pop_front();
				if (want.r !== red_out || want.g !== green_out || want.b !== blue_out) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h, got %h %h %h",
							want.r, want.g, want.b, red_out, green_out, blue_out);
				end
			end
		end
	end

	task automatic drain_pipe();
		wait (pending_pixels.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// one register write per edge, then an ignored write past the last index
	task automatic program_regs(mode_t md, logic [15:0] ratio, logic [15:0] offset,
			logic [15:0] target);
		logic [3:0]  idx[5];
		logic [15:0] val[5];
		idx = '{REG_MODE, REG_RATIO, REG_OFFSET, REG_TARGET, REG_UNUSED};
		val = '{{14'($urandom), md}, ratio, offset, target, 16'($urandom)};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_index <= 4'($urandom);
		cur_mode = md;
		cur_ratio = ratio;
		cur_offset = offset;
		cur_target = target;
		settings_used++;
		@(posedge clk);
	endtask

	// called at a rising edge; returns right after the accepting edge
	task automatic send_pixel(pixel_t px);
		int gap;
		gap = $urandom_range(0, 3);
		if ((pixels_sent / 50) % 4 == 3) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		red_in   <= px.r;
		green_in <= px.g;
		blue_in  <= px.b;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
		pending_pixels.push_back(adjust_pixel(px));
		pixels_sent++;
	endtask

	task automatic close_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		int kind, base;
		kind = $urandom_range(0, 9);
		px.r = 16'($urandom); px.g = 16'($urandom); px.b = 16'($urandom);
		if (kind == 6) begin
			base = $urandom_range(0, 65527);
			px.r = 16'(base + $urandom_range(0, 8));
			px.g = 16'(base + $urandom_range(0, 8));
			px.b = 16'(base + $urandom_range(0, 8));
		end else if (kind == 7) begin
			px.r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			px.g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			px.b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end else if (kind == 8) begin
			px.g = px.r;
		end else if (kind == 9) begin
			px.b = $urandom_range(0, 1) ? px.r : px.g;
		end
		return px;
	endfunction

	row_t dir_rows[] = '{
		'{1, MODE_SHADE, 16'd16384, 16'd0, 16'd32768, 16'd0, 16'd0, 16'd0,
			1, 16'd0, 16'd0, 16'd0},
		'{0, MODE_SHADE, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{0, MODE_SHADE, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
			1, 16'h8000, 16'h8000, 16'h8000},
		'{0, MODE_SHADE, 0, 0, 0, 16'hFFFF, 16'h0000, 16'h0000,
			1, 16'hFFFF, 16'h0000, 16'h0000},
		'{0, MODE_SHADE, 0, 0, 0, 16'h0000, 16'hFFFF, 16'h0000,
			1, 16'h0000, 16'hFFFF, 16'h0000},
		'{0, MODE_SHADE, 0, 0, 0, 16'h0000, 16'h0000, 16'hFFFF,
			1, 16'h0000, 16'h0000, 16'hFFFF},
		'{0, MODE_SHADE, 0, 0, 0, 16'd1000, 16'd1006, 16'd1000, 0, 0, 0, 0},
		'{0, MODE_SHADE, 0, 0, 0, 16'd1000, 16'd1007, 16'd1000, 0, 0, 0, 0},
		'{0, MODE_SHADE, 0, 0, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 0, 0, 0},
		'{0, MODE_SHADE, 0, 0, 0, 16'd12345, 16'd54321, 16'd111, 0, 0, 0, 0},
		'{1, MODE_DRIFT, 16'd16384, 16'd0, 16'd32768, 16'hFFFF, 16'h0000, 16'h0000,
			0, 0, 0, 0},
		'{1, MODE_DRIFT, 16'd0, 16'd0, 16'd32768, 16'd40000, 16'd20000, 16'd10000,
			1, 16'd0, 16'd0, 16'd0},
		'{1, MODE_DRIFT, 16'd16383, 16'd0, 16'd32768, 16'd40000, 16'd20000, 16'd10000,
			0, 0, 0, 0},
		'{1, MODE_DRIFT, 16'hFFFF, 16'd0, 16'd32768, 16'd20000, 16'd30000, 16'd40000,
			0, 0, 0, 0},
		'{1, MODE_SHIFT, 16'd16384, 16'd23040, 16'd32768, 16'd40000, 16'd20000,
			16'd10000, 0, 0, 0, 0},
		'{1, MODE_SHIFT, 16'd16384, 16'h8000, 16'd32768, 16'd40000, 16'd20000,
			16'd10000, 0, 0, 0, 0},
		'{1, MODE_SHIFT, 16'd16384, 16'h7FFF, 16'd32768, 16'd5, 16'd60000, 16'd30000,
			0, 0, 0, 0},
		'{1, MODE_SET, 16'd16384, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
			1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{1, MODE_SET, 16'd16384, 16'd0, 16'd0, 16'hFFFF, 16'h0000, 16'h0000,
			1, 16'd0, 16'd0, 16'd0},
		'{1, MODE_SET, 16'd16384, 16'd0, 16'd32768, 16'd100, 16'd40000, 16'd65000,
			0, 0, 0, 0},
		'{1, MODE_SHADE, 16'hFFFF, 16'd0, 16'd32768, 16'd20000, 16'd30000, 16'd40000,
			0, 0, 0, 0}
	};

	initial begin
		pixel_t      px;
		logic [15:0] ratio, offset, target;
		cur_mode = MODE_SHADE;
		cur_ratio = 16'd16384;
		cur_offset = 16'd0;
		cur_target = 16'd32768;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed-in results are checked on top of the model
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg) begin
				close_burst();
				drain_pipe();
				program_regs(dir_rows[i].md, dir_rows[i].ratio, dir_rows[i].offset,
					dir_rows[i].target);
			end
			px.r = dir_rows[i].r; px.g = dir_rows[i].g; px.b = dir_rows[i].b;
			if (dir_rows[i].chk) begin
				pixel_t typed;
				typed = adjust_pixel(px);
				if (typed.r !== dir_rows[i].er || typed.g !== dir_rows[i].eg ||
						typed.b !== dir_rows[i].eb) begin
					mismatches++;
					$display("table row %0d disagrees with model", i);
				end
			end
			send_pixel(px);
		end

		// random phases, each under its own register setting
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 5)
				0: ratio = 16'd0;
				1: ratio = 16'hFFFF;
				2: ratio = 16'd16384;
				3: ratio = 16'($urandom_range(16000, 16800));
				default: ratio = 16'($urandom);
			endcase
			case (p % 4)
				0: offset = 16'(-23040);
				1: offset = 16'd23040;
				2: offset = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
				default: offset = 16'($urandom);
			endcase
			case (p % 3)
				0: target = 16'd0;
				1: target = 16'hFFFF;
				default: target = 16'($urandom);
			endcase
			close_burst();
			drain_pipe();
			program_regs(mode_t'(p % 4), ratio, offset, target);
			repeat (PHASE_LEN) send_pixel(random_pixel());
		end

		close_burst();
		wait (pending_pixels.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		$display("sent %0d pixels under %0d register settings, %0d results checked",
			pixels_sent, settings_used, results_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/hslca_pkg.sv
sv/hslca_div.sv
sv/hsl_color_adjust.sv
tb/tb.sv
